// ===== design/rbcs_pkg.sv =====
// Shared types and constants for the RGB blink-code sequencer.
// No dependencies; imported by rbcs_seq and rgb_blink_code_sequencer_unit.
`default_nettype none

package rbcs_pkg;

  localparam int CHANNELS = 3;
  localparam int CH_W     = $clog2(CHANNELS + 1);

  // Commands carried by an input item
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POST = 1'b1;

  // State codes posted by the firmware
  localparam logic [2:0] CODE_INIT   = 3'd0;
  localparam logic [2:0] CODE_WIFI_1 = 3'd1;
  localparam logic [2:0] CODE_WIFI_2 = 3'd2;
  localparam logic [2:0] CODE_WIFI_3 = 3'd3;
  localparam logic [2:0] CODE_CAN_1  = 3'd4;
  localparam logic [2:0] CODE_CAN_2  = 3'd5;
  localparam logic [2:0] CODE_WS_1   = 3'd6;
  localparam logic [2:0] CODE_WS_2   = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] REG_FIRST_COLOR  = 2'd0;
  localparam logic [1:0] REG_SECOND_COLOR = 2'd1;
  localparam logic [1:0] REG_THIRD_COLOR  = 2'd2;
  localparam logic [1:0] REG_SLOT_TICKS   = 2'd3;

  localparam logic [23:0] FIRST_COLOR_RST  = 24'd10;
  localparam logic [23:0] SECOND_COLOR_RST = 24'd2560;
  localparam logic [23:0] THIRD_COLOR_RST  = 24'd657930;
  localparam logic [15:0] SLOT_TICKS_RST   = 16'd125;

  localparam logic [2:0] LONG_SLOTS  = 3'd4;
  localparam logic [2:0] SHORT_SLOTS = 3'd1;

  typedef enum logic [2:0] {
    PH_START,
    PH_LONG_ON,
    PH_LONG_OFF,
    PH_SHORT_ON,
    PH_SHORT_OFF,
    PH_TAIL,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [2:0] state_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef struct packed {
    logic [23:0] first_color;
    logic [23:0] second_color;
    logic [23:0] third_color;
    logic [15:0] slot_ticks;
  } cfg_t;

  typedef struct packed {
    logic     fire;
    in_item_t item;
  } seq_ctrl_t;

endpackage

`default_nettype wire

// ===== design/rbcs_seq.sv =====
// Blink-code sequencer state and its per-item update.
// Depends on rbcs_pkg; instantiated by rgb_blink_code_sequencer_unit.
`default_nettype none

module rbcs_seq
  import rbcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire seq_ctrl_t ctrl,
  input  wire cfg_t      cfg,
  output out_item_t      led
);

  logic [1:0]      pulse_counts      [CHANNELS];
  logic [1:0]      pulse_counts_next [CHANNELS];
  logic [CH_W-1:0] active_channel, active_channel_next;
  logic [1:0]      active_count, active_count_next;
  logic [3:0]      round_sum, round_sum_next;
  phase_t          phase, phase_next;
  logic [1:0]      pulse_index, pulse_index_next;
  logic [2:0]      slot_left, slot_left_next;
  logic [15:0]     tick_left, tick_left_next;
  logic            led_on, led_on_next;

  logic [15:0]     slot_len;
  logic            found_a, found_b;
  logic [CH_W-1:0] ch_a, ch_b;
  logic [1:0]      cnt_a, cnt_b;
  logic            post_hit;
  logic [1:0]      post_ch;
  logic [1:0]      post_cnt;

  assign slot_len = (cfg.slot_ticks == 16'd0) ? 16'd1 : cfg.slot_ticks;

  // Find the next channel with a nonzero count, from the current one and from zero
  always_comb begin
    found_a = 1'b0;
    found_b = 1'b0;
    ch_a    = '0;
    ch_b    = '0;
    cnt_a   = '0;
    cnt_b   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (pulse_counts[i] != 2'd0) begin
        found_b = 1'b1;
        ch_b    = CH_W'(i);
        cnt_b   = pulse_counts[i];
        if (CH_W'(i) >= active_channel) begin
          found_a = 1'b1;
          ch_a    = CH_W'(i);
          cnt_a   = pulse_counts[i];
        end
      end
    end
  end

  always_comb begin
    post_hit = 1'b1;
    post_ch  = 2'd0;
    post_cnt = 2'd0;
    unique case (ctrl.item.state_code) inside
      CODE_WIFI_1: begin post_ch = 2'd0; post_cnt = 2'd1; end
      CODE_WIFI_2: begin post_ch = 2'd0; post_cnt = 2'd2; end
      CODE_WIFI_3: begin post_ch = 2'd0; post_cnt = 2'd3; end
      CODE_CAN_1:  begin post_ch = 2'd1; post_cnt = 2'd1; end
      CODE_CAN_2:  begin post_ch = 2'd1; post_cnt = 2'd2; end
      CODE_WS_1:   begin post_ch = 2'd2; post_cnt = 2'd1; end
      CODE_WS_2:   begin post_ch = 2'd2; post_cnt = 2'd2; end
      default:     post_hit = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    logic [4:0] sum;
    pulse_counts_next   = pulse_counts;
    active_channel_next = active_channel;
    active_count_next   = active_count;
    round_sum_next      = round_sum;
    phase_next          = phase;
    pulse_index_next    = pulse_index;
    slot_left_next      = slot_left;
    tick_left_next      = tick_left;
    led_on_next         = led_on;
    sum                 = 5'({1'b0, round_sum} + {3'b0, active_count});

    if (ctrl.item.command == CMD_POST) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (post_hit && int'(post_ch) == i) begin
          pulse_counts_next[i] = post_cnt;
        end
      end
    end else begin
      // Start of a turn: pick the channel, or rest for a long gap
      if (phase == PH_START) begin
        if (found_a || (round_sum != 4'd0 && found_b)) begin
          if (!found_a) begin
            round_sum_next = 4'd0;
          end
          active_channel_next = found_a ? ch_a : ch_b;
          active_count_next   = found_a ? cnt_a : cnt_b;
          pulse_index_next    = 2'd0;
          led_on_next         = 1'b1;
          tick_left_next      = slot_len;
          if ((found_a ? cnt_a : cnt_b) == 2'd1) begin
            phase_next     = PH_LONG_ON;
            slot_left_next = LONG_SLOTS;
          end else begin
            phase_next     = PH_SHORT_ON;
            slot_left_next = SHORT_SLOTS;
          end
        end else begin
          active_channel_next = '0;
          round_sum_next      = 4'd0;
          active_count_next   = 2'd0;
          phase_next          = PH_IDLE;
          slot_left_next      = LONG_SLOTS;
          tick_left_next      = slot_len;
          led_on_next         = 1'b0;
        end
      end

      if (tick_left_next != 16'd0) begin
        tick_left_next = tick_left_next - 16'd1;
      end
      if (tick_left_next == 16'd0) begin
        if (slot_left_next != 3'd0) begin
          slot_left_next = slot_left_next - 3'd1;
        end
        if (slot_left_next != 3'd0) begin
          tick_left_next = slot_len;
        end else begin
          // End of segment
          unique case (phase_next)
            PH_LONG_ON: begin
              phase_next     = PH_LONG_OFF;
              slot_left_next = LONG_SLOTS;
              tick_left_next = slot_len;
              led_on_next    = 1'b0;
            end
            PH_SHORT_ON: begin
              phase_next     = PH_SHORT_OFF;
              slot_left_next = SHORT_SLOTS;
              tick_left_next = slot_len;
              led_on_next    = 1'b0;
            end
            PH_SHORT_OFF: begin
              pulse_index_next = pulse_index_next + 2'd1;
              tick_left_next   = slot_len;
              if (pulse_index_next < active_count_next && pulse_index_next != 2'd0) begin
                phase_next     = PH_SHORT_ON;
                slot_left_next = SHORT_SLOTS;
                led_on_next    = 1'b1;
              end else begin
                phase_next     = PH_TAIL;
                slot_left_next = LONG_SLOTS;
                led_on_next    = 1'b0;
              end
            end
            default: begin
              if (phase_next != PH_IDLE) begin
                sum = 5'({1'b0, round_sum_next} + {3'b0, active_count_next});
                round_sum_next      = (sum > 5'd15) ? 4'd15 : sum[3:0];
                active_channel_next = active_channel_next + CH_W'(1);
              end
              phase_next     = PH_START;
              led_on_next    = 1'b0;
              slot_left_next = 3'd0;
              tick_left_next = 16'd0;
            end
          endcase
        end
      end
    end
  end

  // Output: color of the shown channel after this item
  always_comb begin
    logic [23:0] color;
    color = 24'd0;
    if (led_on_next) begin
      case (int'(active_channel_next))
        0:       color = cfg.first_color;
        1:       color = cfg.second_color;
        2:       color = cfg.third_color;
        default: color = 24'd0;
      endcase
    end
    led.red   = color[23:16];
    led.green = color[15:8];
    led.blue  = color[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pulse_counts[i] <= 2'd0;
      end
      active_channel <= '0;
      active_count   <= 2'd0;
      round_sum      <= 4'd0;
      phase          <= PH_START;
      pulse_index    <= 2'd0;
      slot_left      <= 3'd0;
      tick_left      <= 16'd0;
      led_on         <= 1'b0;
    end else if (ctrl.fire) begin
      pulse_counts   <= pulse_counts_next;
      active_channel <= active_channel_next;
      active_count   <= active_count_next;
      round_sum      <= round_sum_next;
      phase          <= phase_next;
      pulse_index    <= pulse_index_next;
      slot_left      <= slot_left_next;
      tick_left      <= tick_left_next;
      led_on         <= led_on_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/rgb_blink_code_sequencer_unit.sv =====
// Top level of the RGB blink-code sequencer: channels, config registers, pipeline.
// Depends on rbcs_pkg and rbcs_seq.
//
// Usage:
//   Input channel (item_valid / item_stall / item): each item is either a time
//   tick or a post of a state code that sets one channel's pulse count.
//   Output channel (result_valid / result_stall / result): one result per
//   item, the LED red/green/blue level after that item, zero when off.
//   Config port (cfg_we / cfg_index / cfg_data): writes the three channel
//   colors and the slot length in ticks; write only while the block is idle.
//   Flow: an accepted item waits in the input register and is processed when
//   the result register advances; its result is then held in that register.
//   Throughput: one item per cycle while not stalled; the whole update of the
//   sequencer state is a single pass of logic from input to result register.
//   Stall: when result_stall holds a waiting result, the input register fills
//   and then item_stall rises; nothing is dropped.
//   Reset (rst, synchronous): pipeline empties, counts clear, colors and slot
//   length return to their defaults, the sequencer waits at a turn start.
`default_nettype none

module rgb_blink_code_sequencer_unit
  import rbcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire in_item_t  item,
  output logic           result_valid,
  input  wire logic      result_stall,
  output out_item_t      result,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [23:0] cfg_data
);

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      adv;
  logic      fire;
  seq_ctrl_t ctrl;
  out_item_t led;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_color  <= FIRST_COLOR_RST;
      cfg.second_color <= SECOND_COLOR_RST;
      cfg.third_color  <= THIRD_COLOR_RST;
      cfg.slot_ticks   <= SLOT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_COLOR:  cfg.first_color  <= cfg_data;
        REG_SECOND_COLOR: cfg.second_color <= cfg_data;
        REG_THIRD_COLOR:  cfg.third_color  <= cfg_data;
        REG_SLOT_TICKS:   cfg.slot_ticks   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Advance the result register when it is empty or being taken
  assign adv        = !result_valid || !result_stall;
  assign fire       = s1_valid && adv;
  assign item_stall = s1_valid && !adv;

  assign ctrl.fire = fire;
  assign ctrl.item = s1_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  rbcs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .cfg  (cfg),
    .led  (led)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= led;
    end
  end

`ifndef NO_ASSERTIONS
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("processed item did not reach the result register");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_item)))
    else $error("blocked item in the input register was lost or changed");

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled while the result register is empty");
`endif

endmodule

`default_nettype wire
